[hdl/rcs_pkg.sv]
// Package for the range to CIDR splitter: payload structs, the command and status
// structs between controller and datapath, and fixed constants.
// No dependencies.
package rcs_pkg;

  localparam int FieldW = 32;
  localparam int IdxW = 6;
  localparam int CfgW = 6;
  localparam int MaxOut = 62;
  localparam int CntW = 6;
  localparam logic [CfgW-1:0] CfgResetWidth = 6'd32;

  typedef logic [IdxW-1:0] idx_t;

  typedef struct packed {
    logic [FieldW-1:0] range_start;
    logic [FieldW-1:0] range_end;
  } in_t;

  typedef struct packed {
    logic [FieldW-1:0] block_base;
    logic [IdxW-1:0]   prefix_len;
    logic              last_block;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
  } rcs_cmd_t;

  typedef struct packed {
    logic range_empty;
    logic out_free;
    logic last;
  } rcs_sts_t;

endpackage

[hdl/rcs_ctrl.sv]
// Controller of the range to CIDR splitter: sequences loading, block steps and the
// pause after a full run of blocks. Depends on rcs_pkg.
module rcs_ctrl import rcs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rcs_sts_t sts,
  output rcs_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  localparam logic [CntW-1:0] CntLast = CntW'(MaxOut - 1);

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            in_acc;

  assign in_stall = (state_r == ST_RUN);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && !sts.range_empty) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_HOLD: begin
        if (in_acc) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (sts.out_free) begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end else if (cnt_r == CntLast) begin
            state_nxt = ST_HOLD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> cnt_r <= CntLast)
    else $error("block count ran past the per-item limit");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && sts.last |=> state_r == ST_IDLE)
    else $error("controller did not return to idle after the final block");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && !sts.last && cnt_r == CntLast |=> state_r == ST_HOLD)
    else $error("controller did not pause after a full run of blocks");

endmodule

[hdl/rcs_datapath.sv]
// Datapath of the range to CIDR splitter: cursor, remaining length, width register,
// block size selection and the output register. Depends on rcs_pkg.
module rcs_datapath import rcs_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  in_t             in_data,
  input  logic            cfg_wr,
  input  logic [CfgW-1:0] cfg_data,
  input  rcs_cmd_t        cmd,
  output rcs_sts_t        sts,
  output logic            out_valid,
  input  logic            out_stall,
  output out_t            out_data
);

  localparam idx_t AddrBitsIdx = IdxW'(ADDR_BITS);

  logic [CfgW-1:0]      width_r;
  logic [ADDR_BITS-1:0] cur_r;
  logic [ADDR_BITS:0]   rem_r;
  logic                 out_valid_r;
  out_t                 out_data_r;

  logic [ADDR_BITS-1:0] start_m, end_m;
  logic [ADDR_BITS:0]   size;
  idx_t                 eff_w, tz, msb, tz_cap, j;

  assign start_m = in_data.range_start[ADDR_BITS-1:0];
  assign end_m   = in_data.range_end[ADDR_BITS-1:0];
  assign eff_w   = (width_r > AddrBitsIdx) ? AddrBitsIdx : width_r;

  always_comb begin
    tz = AddrBitsIdx;
    for (int i = ADDR_BITS - 1; i >= 0; i--) begin
      if (cur_r[i]) begin
        tz = IdxW'(i);
      end
    end
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i <= ADDR_BITS; i++) begin
      if (rem_r[i]) begin
        msb = IdxW'(i);
      end
    end
  end

  assign tz_cap = (tz > eff_w) ? eff_w : tz;
  assign j      = (tz_cap > msb) ? msb : tz_cap;
  assign size   = (ADDR_BITS + 1)'(1) << j;

  assign sts.range_empty = start_m > end_m;
  assign sts.out_free    = !out_valid_r || !out_stall;
  assign sts.last        = (rem_r == size);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= CfgResetWidth;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        width_r <= cfg_data;
      end
      if (cmd.step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r <= start_m;
      rem_r <= {1'b0, end_m} - {1'b0, start_m} + 1'b1;
    end else if (cmd.step) begin
      cur_r <= cur_r + size[ADDR_BITS-1:0];
      rem_r <= rem_r - size;
    end
    if (cmd.step) begin
      out_data_r.block_base <= FieldW'(cur_r);
      out_data_r.prefix_len <= eff_w - j;
      out_data_r.last_block <= sts.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> sts.out_free)
    else $error("block step while the output register was still held");

  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && !sts.last |=> rem_r != '0)
    else $error("remaining length emptied without a final block");

endmodule

[hdl/range_to_cidr_splitter.sv]
// Range to CIDR splitter top level: joins the controller and the datapath.
// Depends on rcs_pkg, rcs_ctrl and rcs_datapath.
//
// An input beat carries an inclusive range (range_start, range_end). The block
// answers with the fewest aligned power-of-two blocks covering it, in ascending
// order, each as a base address and a prefix length, the final one marked by
// last_block. A range whose start is above its end yields no beat at all.
// An accepted range is loaded into the cursor and remaining-length registers, then
// each block is stepped into the output register, one per cycle while the output is
// not stalled. The rate is set by the single block-size step in the datapath, which
// produces one block a cycle. At most 62 blocks are given per input beat: if a range
// needs more, which only happens with a narrow configured width, the next input beat
// is taken in place of a new range and its fields are ignored while up to 62 follow.
// The width register is written on the cfg channel, which is always ready, and
// must only be written while no range is in progress. A stall on the output holds
// the current beat and pauses splitting; the input is stalled while blocks are being
// stepped out. Synchronous reset returns the block to idle with a width of 32.
module range_to_cidr_splitter import rcs_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_t             in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_t            out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CfgW-1:0] cfg_data
);

  rcs_cmd_t cmd;
  rcs_sts_t sts;

  assign cfg_ready = 1'b1;

  rcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcs_datapath #(
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[verif/range_to_cidr_splitter_tb.sv]
// Self-checking testbench for range_to_cidr_splitter: directed and random ranges at several widths.
// Expected blocks come from a predictor held in this file, with random idling on both sides.
// Depends on rcs_pkg and range_to_cidr_splitter.
module range_to_cidr_splitter_tb;
  import rcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 8;
  localparam int PhaseItems = 80;
  localparam int NumPhases = 5;
  localparam int NumRows = 21;

  typedef enum logic [1:0] {CHK_MODEL, CHK_ONE_BLOCK, CHK_NO_BLOCK} row_check_t;

  typedef struct {
    logic [CfgW-1:0]   width;
    row_check_t        check;
    in_t               beat;
    logic [FieldW-1:0] base;
    logic [IdxW-1:0]   prefix;
  } stim_row_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  in_t             in_data;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_t            out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CfgW-1:0] cfg_data;

  out_t            pending_blocks[$];
  logic [32:0]     split_cursor;
  logic [31:0]     split_end;
  bit              split_busy;
  logic [CfgW-1:0] width_reg;
  bit              calm;
  int              fail_count;
  int              cycle_count;

  stim_row_t dir_rows [NumRows] = '{
    '{6'd32, CHK_ONE_BLOCK, '{32'h0000_0000, 32'hFFFF_FFFF}, 32'h0000_0000, 6'd0},
    '{6'd32, CHK_ONE_BLOCK, '{32'hFFFF_FFFF, 32'hFFFF_FFFF}, 32'hFFFF_FFFF, 6'd32},
    '{6'd32, CHK_NO_BLOCK,  '{32'h0000_0005, 32'h0000_0004}, 32'h0, 6'd0},
    '{6'd32, CHK_NO_BLOCK,  '{32'hFFFF_FFFF, 32'h0000_0000}, 32'h0, 6'd0},
    '{6'd32, CHK_ONE_BLOCK, '{32'h0000_0000, 32'h0000_0000}, 32'h0000_0000, 6'd32},
    '{6'd32, CHK_MODEL,     '{32'h0000_0001, 32'hFFFF_FFFE}, 32'h0, 6'd0},
    '{6'd32, CHK_ONE_BLOCK, '{32'h8000_0000, 32'hFFFF_FFFF}, 32'h8000_0000, 6'd1},
    '{6'd32, CHK_ONE_BLOCK, '{32'h0000_0000, 32'h7FFF_FFFF}, 32'h0000_0000, 6'd1},
    '{6'd32, CHK_MODEL,     '{32'h1234_5678, 32'h9ABC_DEF0}, 32'h0, 6'd0},
    '{6'd32, CHK_MODEL,     '{32'h5555_5555, 32'hAAAA_AAAA}, 32'h0, 6'd0},
    '{6'd63, CHK_ONE_BLOCK, '{32'h0000_0010, 32'h0000_001F}, 32'h0000_0010, 6'd28},
    '{6'd40, CHK_ONE_BLOCK, '{32'h0000_0000, 32'hFFFF_FFFF}, 32'h0000_0000, 6'd0},
    '{6'd0,  CHK_ONE_BLOCK, '{32'h0000_0007, 32'h0000_0007}, 32'h0000_0007, 6'd0},
    '{6'd0,  CHK_MODEL,     '{32'h0000_0000, 32'h0000_0063}, 32'h0, 6'd0},
    '{6'd0,  CHK_MODEL,     '{32'hFFFF_FFFF, 32'h0000_0000}, 32'h0, 6'd0},
    '{6'd1,  CHK_ONE_BLOCK, '{32'h0000_0000, 32'h0000_0001}, 32'h0000_0000, 6'd0},
    '{6'd1,  CHK_MODEL,     '{32'h0000_0003, 32'h0000_0012}, 32'h0, 6'd0},
    '{6'd8,  CHK_ONE_BLOCK, '{32'h0000_0000, 32'h0000_00FF}, 32'h0000_0000, 6'd0},
    '{6'd8,  CHK_MODEL,     '{32'h0000_0100, 32'h0000_03FF}, 32'h0, 6'd0},
    '{6'd32, CHK_ONE_BLOCK, '{32'hFFFF_FFF0, 32'hFFFF_FFFF}, 32'hFFFF_FFF0, 6'd28},
    '{6'd32, CHK_MODEL,     '{32'hFFFF_FFF1, 32'hFFFF_FFFF}, 32'h0, 6'd0}
  };

  range_to_cidr_splitter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned eff_width();
    return (width_reg > 6'd32) ? 32 : int'(width_reg);
  endfunction

  // Queues the blocks that one accepted input beat releases and returns how many.
  function automatic int split_range(input in_t beat);
    int unsigned w;
    int unsigned j;
    int          n;
    logic [33:0] cur;
    logic [33:0] nxt;
    out_t        blk;
    w = eff_width();
    n = 0;
    if (!split_busy) begin
      if (beat.range_start > beat.range_end) return 0;
      split_cursor = {1'b0, beat.range_start};
      split_end = beat.range_end;
      split_busy = 1'b1;
    end
    while (split_busy && n < MaxOut) begin
      cur = {1'b0, split_cursor};
      j = 0;
      while (j < w && cur[j] == 1'b0) j++;
      while (j > 0 && cur + ((34'd1 << j) - 34'd1) > {2'b00, split_end}) j--;
      nxt = cur + (34'd1 << j);
      split_cursor = nxt[32:0];
      blk.block_base = cur[31:0];
      blk.prefix_len = IdxW'(w - j);
      blk.last_block = (split_cursor > {1'b0, split_end}) || (split_cursor <= cur[32:0]);
      if (blk.last_block) split_busy = 1'b0;
      pending_blocks.push_back(blk);
      n++;
    end
    return n;
  endfunction

  function automatic in_t random_range();
    in_t         r;
    int unsigned nb;
    int unsigned pick;
    logic [31:0] len;
    logic [31:0] a;
    logic [31:0] b;
    nb = $urandom_range(0, (eff_width() + 3 > 32) ? 32 : eff_width() + 3);
    len = (nb == 32) ? $urandom : ($urandom & ((32'd1 << nb) - 32'd1));
    pick = $urandom_range(99);
    r.range_start = $urandom;
    if (pick < 25) r.range_start &= ~((32'd1 << $urandom_range(0, 31)) - 32'd1);
    r.range_end = r.range_start + len;
    if (r.range_end < r.range_start) r.range_end = 32'hFFFF_FFFF;
    if (pick >= 84 && pick < 92) begin
      r.range_end = 32'hFFFF_FFFF;
      r.range_start = 32'hFFFF_FFFF - len;
    end else if (pick >= 92) begin
      a = $urandom;
      b = $urandom;
      if (a == b) b = a ^ 32'd1;
      r.range_start = (a > b) ? a : b;
      r.range_end = (a > b) ? b : a;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic send_beat(input in_t beat, output int produced);
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    produced = split_range(beat);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    int produced;
    while (split_busy) send_beat(in_t'({$urandom, $urandom}), produced);
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_width(input logic [CfgW-1:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_reg = w;
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 31);
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_blocks.size() == 0) begin
        note_mismatch($sformatf("unexpected block: base %h prefix %0d last %b",
                                out_data.block_base, out_data.prefix_len,
                                out_data.last_block));
      end else begin
        want = pending_blocks.pop_front();
        if (out_data.block_base !== want.block_base)
          note_mismatch($sformatf("block_base: expected %h, got %h",
                                  want.block_base, out_data.block_base));
        if (out_data.prefix_len !== want.prefix_len)
          note_mismatch($sformatf("prefix_len at %h: expected %0d, got %0d",
                                  want.block_base, want.prefix_len, out_data.prefix_len));
        if (out_data.last_block !== want.last_block)
          note_mismatch($sformatf("last_block at %h: expected %b, got %b",
                                  want.block_base, want.last_block, out_data.last_block));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("range_to_cidr_splitter_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int              produced;
    int              k;
    in_t             beat;
    out_t            typed;
    logic [CfgW-1:0] phase_w [NumPhases];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    calm = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    width_reg = CfgResetWidth;
    split_busy = 1'b0;
    split_cursor = '0;
    split_end = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].width != width_reg) set_width(dir_rows[i].width);
      send_beat(dir_rows[i].beat, produced);
      if (dir_rows[i].check != CHK_MODEL) begin
        repeat (produced) void'(pending_blocks.pop_back());
        if (dir_rows[i].check == CHK_ONE_BLOCK) begin
          typed.block_base = dir_rows[i].base;
          typed.prefix_len = dir_rows[i].prefix;
          typed.last_block = 1'b1;
          pending_blocks.push_back(typed);
        end
      end
      sender_gap();
    end

    phase_w[0] = 6'd32;
    phase_w[1] = CfgW'($urandom_range(24, 31));
    phase_w[2] = CfgW'($urandom_range(9, 23));
    phase_w[3] = CfgW'($urandom_range(0, 8));
    phase_w[4] = 6'd63;
    for (int p = 0; p < NumPhases; p++) begin
      set_width(phase_w[p]);
      k = 0;
      while (k < PhaseItems) begin
        calm = (p == 2) && (k < 50);
        if (split_busy) begin
          beat = in_t'({$urandom, $urandom});
        end else begin
          beat = random_range();
          k++;
        end
        send_beat(beat, produced);
        sender_gap();
      end
      calm = 1'b0;
    end

    drain();
    if (fail_count == 0 && pending_blocks.size() == 0) begin
      $display("range_to_cidr_splitter_tb: PASS");
    end else begin
      $display("range_to_cidr_splitter_tb: FAIL");
    end
    $finish;
  end

endmodule
